// File: design/bfd_pkg.sv
// bfd_pkg: shared types and constants of the box filter downsampler
// holds pixel and result beat types, configuration layout and command/status structs
// depends on nothing
`default_nettype none

package bfd_pkg;

    // field widths
    localparam int PIX_W     = 8;
    localparam int DIM_W     = 11;
    localparam int FACT_W    = 5;
    localparam int LANE_W    = 16;
    localparam int LANES     = 4;
    localparam int WORD_W    = LANE_W * LANES;
    localparam int QUO_W     = 8;
    localparam int ROW_W     = 10;

    // limits and defaults
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_FACTOR = 16;
    localparam int HEIGHT_LIMIT   = 1024;

    localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = DIM_W'(480);
    localparam logic [FACT_W-1:0] RST_SCALE_FACTOR = FACT_W'(2);

    // configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_SCALE_FACTOR = 2'd2;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
    } t_pixel;

    typedef struct packed {
        logic [PIX_W-1:0] mean_red;
        logic [PIX_W-1:0] mean_green;
        logic [PIX_W-1:0] mean_blue;
        logic [PIX_W-1:0] mean_alpha;
        logic             row_end;
        logic             frame_end;
    } t_result;

    typedef struct packed {
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  image_height;
        logic [FACT_W-1:0] scale_factor;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic              accept;     // take pixel beat, issue line store read
        logic              clear;      // first pixel of a block: start sum from zero
        logic              row_end;
        logic              frame_end;
        logic [FACT_W-1:0] factor;     // clamped block edge
        logic              acc;        // add and write back
        logic              div_step;   // one quotient bit
        logic              load;       // move quotient into output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// File: design/bfd_regs.sv
// bfd_regs: APB-style configuration registers of the box filter downsampler
// depends on bfd_pkg
`default_nettype none

module bfd_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bfd_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [bfd_pkg::DATA_W-1:0]   pwdata,
    output logic      [bfd_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,
    output bfd_pkg::t_cfg                     o_cfg,
    output logic                              o_restart
);

    logic [bfd_pkg::DIM_W-1:0]  r_image_width;
    logic [bfd_pkg::DIM_W-1:0]  r_image_height;
    logic [bfd_pkg::FACT_W-1:0] r_scale_factor;
    logic [bfd_pkg::IDX_W-1:0]  reg_idx;
    logic                       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[bfd_pkg::ADDR_W-1:bfd_pkg::ADDR_W-bfd_pkg::IDX_W];
    assign wr_en   = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= bfd_pkg::RST_IMAGE_WIDTH;
            r_image_height <= bfd_pkg::RST_IMAGE_HEIGHT;
            r_scale_factor <= bfd_pkg::RST_SCALE_FACTOR;
        end else if (wr_en) begin
            case (reg_idx)
                bfd_pkg::REG_IMAGE_WIDTH:  r_image_width  <= pwdata[bfd_pkg::DIM_W-1:0];
                bfd_pkg::REG_IMAGE_HEIGHT: r_image_height <= pwdata[bfd_pkg::DIM_W-1:0];
                bfd_pkg::REG_SCALE_FACTOR: r_scale_factor <= pwdata[bfd_pkg::FACT_W-1:0];
                default: ;
            endcase
        end
    end

    // a write to a known register restarts the frame position
    always_comb begin
        case (reg_idx)
            bfd_pkg::REG_IMAGE_WIDTH,
            bfd_pkg::REG_IMAGE_HEIGHT,
            bfd_pkg::REG_SCALE_FACTOR: o_restart = wr_en;
            default:                   o_restart = 1'b0;
        endcase
    end

    // read back
    always_comb begin
        case (reg_idx)
            bfd_pkg::REG_IMAGE_WIDTH:  prdata = bfd_pkg::DATA_W'(r_image_width);
            bfd_pkg::REG_IMAGE_HEIGHT: prdata = bfd_pkg::DATA_W'(r_image_height);
            bfd_pkg::REG_SCALE_FACTOR: prdata = bfd_pkg::DATA_W'(r_scale_factor);
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg.image_width  = r_image_width;
    assign o_cfg.image_height = r_image_height;
    assign o_cfg.scale_factor = r_scale_factor;

endmodule

`default_nettype wire

// File: design/bfd_ctrl.sv
// bfd_ctrl: controller of the box filter downsampler
// frame position counters, block bookkeeping and the sequencing state machine
// depends on bfd_pkg
`default_nettype none

module bfd_ctrl #(
    parameter int MAX_WIDTH  = bfd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = bfd_pkg::DEF_MAX_FACTOR
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire bfd_pkg::t_cfg                   i_cfg,
    input  wire logic                            i_restart,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire bfd_pkg::t_sts                   i_sts,
    output bfd_pkg::t_cmd                        o_cmd,
    output logic [$clog2(MAX_WIDTH)-1:0]         o_idx
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int CW  = (WW > bfd_pkg::DIM_W) ? WW : bfd_pkg::DIM_W;
    localparam int CCW = $clog2(MAX_WIDTH);
    localparam int CBW = $clog2(MAX_FACTOR);
    localparam int SW  = $clog2(bfd_pkg::QUO_W);
    localparam int FW  = bfd_pkg::FACT_W;
    localparam int HW  = bfd_pkg::DIM_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ACC  = 4'b0010,
        S_DIV  = 4'b0100,
        S_LOAD = 4'b1000
    } t_state;

    t_state                    r_state, n_state;
    logic [CCW-1:0]            r_col, n_col;
    logic [CCW-1:0]            r_bcol, n_bcol;
    logic [bfd_pkg::ROW_W-1:0] r_row, n_row;
    logic [CBW-1:0]            r_cib, n_cib;
    logic [CBW-1:0]            r_rib, n_rib;
    logic [SW-1:0]             r_step, n_step;
    logic                      r_emit, n_emit;

    logic [CW-1:0]             w_eff;
    logic [HW-1:0]             h_eff;
    logic [FW-1:0]             f_eff;
    logic                      accept;
    logic                      col_last, cib_last, row_last, rib_last;
    logic                      emit;

    // clamp configuration to the legal ranges
    always_comb begin
        if (CW'(i_cfg.image_width) == '0)
            w_eff = CW'(1);
        else if (CW'(i_cfg.image_width) > CW'(MAX_WIDTH))
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(i_cfg.image_width);

        if (i_cfg.image_height == '0)
            h_eff = HW'(1);
        else if (i_cfg.image_height > HW'(bfd_pkg::HEIGHT_LIMIT))
            h_eff = HW'(bfd_pkg::HEIGHT_LIMIT);
        else
            h_eff = i_cfg.image_height;

        if (i_cfg.scale_factor == '0)
            f_eff = FW'(1);
        else if (i_cfg.scale_factor > FW'(MAX_FACTOR))
            f_eff = FW'(MAX_FACTOR);
        else
            f_eff = i_cfg.scale_factor;
    end

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    // position flags of the current pixel
    assign col_last = (CW'(r_col) + CW'(1)) >= w_eff;
    assign row_last = (HW'(r_row) + HW'(1)) >= h_eff;
    assign cib_last = (FW'(r_cib) + FW'(1)) >= f_eff;
    assign rib_last = (FW'(r_rib) + FW'(1)) >= f_eff;
    // bottom-right pixel of a block always lies inside the image, so the block is whole
    assign emit     = cib_last && rib_last;

    // command to the datapath
    always_comb begin
        o_cmd.accept    = accept;
        o_cmd.clear     = (r_cib == '0) && (r_rib == '0);
        // no further whole block fits to the right / below
        o_cmd.row_end   = ((CW+1)'(r_col) + (CW+1)'(1) + (CW+1)'(f_eff)) > (CW+1)'(w_eff);
        o_cmd.frame_end = o_cmd.row_end &&
                          (((HW+1)'(r_row) + (HW+1)'(1) + (HW+1)'(f_eff)) > (HW+1)'(h_eff));
        o_cmd.factor    = f_eff;
        o_cmd.acc       = (r_state == S_ACC);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.load      = (r_state == S_LOAD) && i_sts.out_free;
    end

    assign o_idx = r_bcol;

    // frame position counters
    always_comb begin
        n_col  = r_col;
        n_bcol = r_bcol;
        n_row  = r_row;
        n_cib  = r_cib;
        n_rib  = r_rib;
        if (i_restart) begin
            n_col  = '0;
            n_bcol = '0;
            n_row  = '0;
            n_cib  = '0;
            n_rib  = '0;
        end else if (accept) begin
            if (col_last) begin
                n_col  = '0;
                n_bcol = '0;
                n_cib  = '0;
                n_row  = row_last ? '0 : r_row + 1'b1;
                n_rib  = (row_last || rib_last) ? '0 : r_rib + 1'b1;
            end else begin
                n_col  = r_col + 1'b1;
                n_cib  = cib_last ? '0 : r_cib + 1'b1;
                n_bcol = cib_last ? r_bcol + 1'b1 : r_bcol;
            end
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_emit  = r_emit;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_emit  = emit;
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_step  = '0;
                n_state = r_emit ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                n_step = r_step + 1'b1;
                if (r_step == SW'(bfd_pkg::QUO_W - 1))
                    n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.out_free)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_emit  <= 1'b0;
            r_col   <= '0;
            r_bcol  <= '0;
            r_row   <= '0;
            r_cib   <= '0;
            r_rib   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_emit  <= n_emit;
            r_col   <= n_col;
            r_bcol  <= n_bcol;
            r_row   <= n_row;
            r_cib   <= n_cib;
            r_rib   <= n_rib;
        end
    end

    // checks
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state not one-hot");

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_col) < w_eff)
        else $error("column count beyond row width");

    a_cib_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        FW'(r_cib) < f_eff && FW'(r_rib) < f_eff)
        else $error("position in block beyond block edge");

    a_accept_to_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_ACC))
        else $error("accepted beat not followed by accumulate");

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_step == SW'(bfd_pkg::QUO_W - 1)) |=> (r_state == S_LOAD))
        else $error("divider did not end after all quotient bits");

endmodule

`default_nettype wire

// File: design/bfd_dp.sv
// bfd_dp: datapath of the box filter downsampler
// line store of block sums, lane adders, bit-serial divider and output register
// depends on bfd_pkg
`default_nettype none

module bfd_dp #(
    parameter int MAX_WIDTH = bfd_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire bfd_pkg::t_cmd               i_cmd,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] i_idx,
    input  wire bfd_pkg::t_pixel             i_pixel,
    output bfd_pkg::t_sts                    o_sts,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output bfd_pkg::t_result                 o_result
);

    localparam int CCW = $clog2(MAX_WIDTH);
    localparam int LW  = bfd_pkg::LANE_W;
    localparam int NL  = bfd_pkg::LANES;
    localparam int QW  = bfd_pkg::QUO_W;
    localparam int PW  = bfd_pkg::PIX_W;
    localparam int FW  = bfd_pkg::FACT_W;
    localparam int AW  = 2 * FW;

    logic [bfd_pkg::WORD_W-1:0] r_line_mem [MAX_WIDTH];
    logic [bfd_pkg::WORD_W-1:0] r_rdata;
    logic [bfd_pkg::WORD_W-1:0] n_word;
    logic [CCW-1:0]             r_idx;
    bfd_pkg::t_pixel            r_px;
    logic                       r_clear;
    logic                       r_row_end;
    logic                       r_frame_end;
    logic [FW-1:0]              r_factor;
    logic [LW-1:0]              r_rem [NL];
    logic [QW-1:0]              r_quo [NL];
    logic [LW-1:0]              r_div;
    bfd_pkg::t_result           r_out;
    logic                       r_out_valid;
    logic [PW-1:0]              px [NL];
    logic [AW-1:0]              area;

    assign px[0] = r_px.red;
    assign px[1] = r_px.green;
    assign px[2] = r_px.blue;
    assign px[3] = r_px.alpha;

    // pixel beat capture and line store read
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_px        <= i_pixel;
            r_idx       <= i_idx;
            r_clear     <= i_cmd.clear;
            r_row_end   <= i_cmd.row_end;
            r_frame_end <= i_cmd.frame_end;
            r_factor    <= i_cmd.factor;
            r_rdata     <= r_line_mem[i_idx];
        end
    end

    // lane sums, restarted from zero on the first pixel of a block
    always_comb begin
        for (int k = 0; k < NL; k++) begin
            n_word[k*LW +: LW] = (r_clear ? LW'(0) : r_rdata[k*LW +: LW]) + LW'(px[k]);
        end
    end

    assign area = AW'(r_factor) * AW'(r_factor);

    // line store write back
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc)
            r_line_mem[r_idx] <= n_word;
    end

    // restoring divider, one quotient bit per cycle for all four lanes
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_div <= LW'(area) << (QW - 1);
            for (int k = 0; k < NL; k++) begin
                r_rem[k] <= n_word[k*LW +: LW];
                r_quo[k] <= '0;
            end
        end else if (i_cmd.div_step) begin
            r_div <= r_div >> 1;
            for (int k = 0; k < NL; k++) begin
                if (r_rem[k] >= r_div) begin
                    r_rem[k] <= r_rem[k] - r_div;
                    r_quo[k] <= {r_quo[k][QW-2:0], 1'b1};
                end else begin
                    r_quo[k] <= {r_quo[k][QW-2:0], 1'b0};
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out.mean_red   <= PW'(r_quo[0]);
            r_out.mean_green <= PW'(r_quo[1]);
            r_out.mean_blue  <= PW'(r_quo[2]);
            r_out.mean_alpha <= PW'(r_quo[3]);
            r_out.row_end    <= r_row_end;
            r_out.frame_end  <= r_frame_end;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_ready;
    assign o_valid        = r_out_valid;
    assign o_result       = r_out;

endmodule

`default_nettype wire

// File: design/box_filter_downsampler_unit.sv
// box_filter_downsampler_unit: top level of the box filter downsampler
// joins configuration registers, controller and datapath; depends on bfd_pkg,
// bfd_regs, bfd_ctrl and bfd_dp
`default_nettype none

// Takes RGBA pixels of a frame in raster order and gives one pixel per
// scale_factor x scale_factor block, the truncated mean of each channel, with
// row_end and frame_end marking the last block of a block row and of the frame.
// Rows and columns that do not make up a whole block are taken and dropped.
// A pixel that does not complete a block goes through the line store read and
// then the add and write back. The bottom-right pixel of a block goes through
// those two steps, the one-bit-per-cycle divider and the load of the output
// register, and the load waits while that register is still held by the
// downstream side. The result waits in that register while the next pixels are
// taken. Block sums need no clearing pass after reset: each block starts its sum
// from zero on its first pixel. Writing any register restarts the frame at its
// top-left pixel; write registers only while no pixel is in flight.
module box_filter_downsampler_unit #(
    parameter int MAX_WIDTH  = bfd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = bfd_pkg::DEF_MAX_FACTOR
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // pixel beats in
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire bfd_pkg::t_pixel             i_pixel,
    // block means out
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output bfd_pkg::t_result                 o_result,
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bfd_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [bfd_pkg::DATA_W-1:0]  pwdata,
    output logic      [bfd_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    bfd_pkg::t_cfg                  cfg;
    bfd_pkg::t_cmd                  cmd;
    bfd_pkg::t_sts                  sts;
    logic                           restart;
    logic [$clog2(MAX_WIDTH)-1:0]   idx;

    bfd_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg     (cfg),
        .o_restart (restart)
    );

    bfd_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_restart (restart),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_idx     (idx)
    );

    bfd_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_idx    (idx),
        .i_pixel  (i_pixel),
        .o_sts    (sts),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// File: tb/box_filter_downsampler_checker.sv
`timescale 1ns / 100ps
// box_filter_downsampler_checker: scoreboard of the downsampler testbench
// watches pixel, result and register beats, predicts block means, compares; uses bfd_pkg
module box_filter_downsampler_checker #(
    parameter int MAX_WIDTH  = bfd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = bfd_pkg::DEF_MAX_FACTOR
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_pix_valid,
    input  logic                        i_pix_ready,
    input  bfd_pkg::t_pixel             i_pixel,
    input  logic                        i_res_valid,
    input  logic                        i_res_ready,
    input  bfd_pkg::t_result            i_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bfd_pkg::ADDR_W-1:0]  paddr,
    input  logic [bfd_pkg::DATA_W-1:0]  pwdata,
    input  logic                        pready,
    output int                          o_errors,
    output int                          o_pending
);
    import bfd_pkg::*;

    localparam int SHOWN_MISMATCHES = 10;

    // line store of per-block-column lane sums, lane 0 red up to lane 3 alpha
    logic [LANES-1:0][LANE_W-1:0] column_sums [MAX_WIDTH];
    logic [DIM_W-1:0]             width_reg;
    logic [DIM_W-1:0]             height_reg;
    logic [FACT_W-1:0]            factor_reg;
    int unsigned                  col_pos;
    int unsigned                  row_pos;
    int unsigned                  col_in_blk;
    int unsigned                  row_in_blk;
    t_result                      expected_means [$];
    int                           errors;
    logic                         known_reg;

    // zero maps to one, anything over the limit saturates
    function automatic int unsigned clamp_to(input int unsigned v, input int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic restart_frame();
        col_pos    = 0;
        row_pos    = 0;
        col_in_blk = 0;
        row_in_blk = 0;
    endtask

    // add one pixel into its block column, queue a mean when the block completes
    task automatic accumulate_pixel(input t_pixel px);
        int unsigned                  w;
        int unsigned                  h;
        int unsigned                  f;
        int unsigned                  out_cols;
        int unsigned                  out_rows;
        int unsigned                  bcol;
        int unsigned                  brow;
        int unsigned                  slot;
        int                           k;
        logic [LANES-1:0][LANE_W-1:0] sums;
        logic [LANES-1:0][PIX_W-1:0]  chan;
        t_result                      mean;

        w        = clamp_to(width_reg, MAX_WIDTH);
        h        = clamp_to(height_reg, HEIGHT_LIMIT);
        f        = clamp_to(factor_reg, MAX_FACTOR);
        out_cols = w / f;
        out_rows = h / f;
        bcol     = col_pos / f;
        brow     = row_pos / f;
        slot     = bcol % MAX_WIDTH;
        chan     = {px.alpha, px.blue, px.green, px.red};

        // first pixel of a block starts from zero
        sums = (row_in_blk == 0 && col_in_blk == 0) ? '0 : column_sums[slot];
        for (k = 0; k < LANES; k++) begin
            sums[k] = sums[k] + LANE_W'(chan[k]);
        end
        column_sums[slot] = sums;

        if (row_in_blk == f - 1 && col_in_blk == f - 1 && bcol < out_cols && brow < out_rows) begin
            mean.mean_red   = PIX_W'(sums[0] / (f * f));
            mean.mean_green = PIX_W'(sums[1] / (f * f));
            mean.mean_blue  = PIX_W'(sums[2] / (f * f));
            mean.mean_alpha = PIX_W'(sums[3] / (f * f));
            mean.row_end    = (bcol == out_cols - 1);
            mean.frame_end  = (bcol == out_cols - 1) && (brow == out_rows - 1);
            expected_means.push_back(mean);
        end

        // raster position
        col_pos++;
        col_in_blk++;
        if (col_in_blk >= f) col_in_blk = 0;
        if (col_pos >= w) begin
            col_pos    = 0;
            col_in_blk = 0;
            row_pos++;
            row_in_blk++;
            if (row_in_blk >= f) row_in_blk = 0;
            if (row_pos >= h) begin
                row_pos    = 0;
                row_in_blk = 0;
            end
        end
    endtask

    // result beat against the oldest expected mean
    task automatic check_mean(input t_result got);
        t_result want;

        if (expected_means.size() == 0) begin
            errors++;
            if (errors <= SHOWN_MISMATCHES)
                $display("unexpected mean beat r=%0d g=%0d b=%0d a=%0d row_end=%b frame_end=%b",
                         got.mean_red, got.mean_green, got.mean_blue, got.mean_alpha,
                         got.row_end, got.frame_end);
            return;
        end
        want = expected_means.pop_front();
        if (got.mean_red !== want.mean_red || got.mean_green !== want.mean_green ||
            got.mean_blue !== want.mean_blue || got.mean_alpha !== want.mean_alpha ||
            got.row_end !== want.row_end || got.frame_end !== want.frame_end) begin
            errors++;
            if (errors <= SHOWN_MISMATCHES)
                $display("mean mismatch: expected r=%0d g=%0d b=%0d a=%0d re=%b fe=%b, %s",
                         want.mean_red, want.mean_green, want.mean_blue, want.mean_alpha,
                         want.row_end, want.frame_end,
                         $sformatf("got r=%0d g=%0d b=%0d a=%0d re=%b fe=%b",
                                   got.mean_red, got.mean_green, got.mean_blue,
                                   got.mean_alpha, got.row_end, got.frame_end));
        end
    endtask

    // all channels sampled at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = RST_IMAGE_WIDTH;
            height_reg = RST_IMAGE_HEIGHT;
            factor_reg = RST_SCALE_FACTOR;
            for (int s = 0; s < MAX_WIDTH; s++) column_sums[s] = '0;
            restart_frame();
            expected_means.delete();
            errors = 0;
        end else begin
            if (i_res_valid && i_res_ready) check_mean(i_result);

            // a write to a known register restarts the frame position
            if (psel && penable && pwrite && pready) begin
                known_reg = 1'b1;
                case (paddr[ADDR_W-1:2])
                    REG_IMAGE_WIDTH:  width_reg  = pwdata[DIM_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg = pwdata[DIM_W-1:0];
                    REG_SCALE_FACTOR: factor_reg = pwdata[FACT_W-1:0];
                    default:          known_reg  = 1'b0;
                endcase
                if (known_reg) restart_frame();
            end

            if (i_pix_valid && i_pix_ready) accumulate_pixel(i_pixel);
        end
        o_errors  <= errors;
        o_pending <= expected_means.size();
    end

endmodule

// File: tb/box_filter_downsampler_unit_test.sv
`timescale 1ns / 100ps
// box_filter_downsampler_unit_test: top of the downsampler testbench
// drives pixel beats, register writes and back-pressure, gives the verdict;
// uses bfd_pkg, box_filter_downsampler_unit and box_filter_downsampler_checker
module box_filter_downsampler_unit_test;
    import bfd_pkg::*;

    localparam int RANDOM_PIXELS  = 350;
    localparam int SETTLE_CYCLES  = 16;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum int {TONE_ANY, TONE_HIGH, TONE_LOW, TONE_EDGE} t_tone;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic               o_ready;
    t_pixel             i_pixel      = '0;
    logic               o_valid;
    logic               i_ready      = 1'b0;
    t_result            o_result;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [ADDR_W-1:0]  paddr        = '0;
    logic [DATA_W-1:0]  pwdata       = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               pixel_taken  = 1'b0;
    int                 errors;
    int                 pending;
    int                 quiet_cycles = 0;
    int                 gap_burst    = 0;
    int                 stall_burst  = 0;
    int                 stall_left   = 0;

    box_filter_downsampler_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_pixel  (i_pixel),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    box_filter_downsampler_checker mean_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_valid),
        .i_pix_ready (o_ready),
        .i_pixel     (i_pixel),
        .i_res_valid (o_valid),
        .i_res_ready (i_ready),
        .i_result    (o_result),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // pixel acceptance seen by the sender at the following falling edge
    always @(posedge i_clk) begin
        pixel_taken <= i_valid && o_ready;
    end

    // watchdog on cycles with no beat on any port
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable && pwrite)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // idle length: mostly short, a few long
    function automatic int pick_idle();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sender gap before the next pixel beat, with stretches of none
    function automatic int next_gap();
        if (gap_burst > 0) begin
            gap_burst--;
            return 0;
        end
        if ($urandom_range(0, 199) == 0) begin
            gap_burst = $urandom_range(50, 300);
            return 0;
        end
        if ($urandom_range(0, 99) < 30) return pick_idle();
        return 0;
    endfunction

    // result back-pressure
    always @(negedge i_clk) begin
        if (stall_burst > 0) begin
            stall_burst--;
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 499) == 0) begin
            stall_burst = $urandom_range(50, 300);
            i_ready <= 1'b1;
        end else if ($urandom_range(0, 99) < 30) begin
            stall_left = pick_idle() - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    function automatic logic [PIX_W-1:0] tone_value(input t_tone tone);
        case (tone)
            TONE_HIGH: return PIX_W'($urandom_range(224, 255));
            TONE_LOW:  return PIX_W'($urandom_range(0, 31));
            TONE_EDGE: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            default:   return PIX_W'($urandom);
        endcase
    endfunction

    // one pixel beat, held until taken
    task automatic send_pixel(input t_pixel px);
        int gap;

        gap = next_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_pixel = px;
        @(negedge i_clk);
        while (!pixel_taken) @(negedge i_clk);
    endtask

    task automatic drain_results();
        while (pending != 0) @(negedge i_clk);
    endtask

    // no pixel in flight and no mean outstanding
    task automatic wait_idle();
        i_valid = 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // setup then access cycle
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = ADDR_W'({idx, 2'b00});
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic configure(input int unsigned w, input int unsigned h, input int unsigned f);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_SCALE_FACTOR, f);
    endtask

    initial begin
        int unsigned sent;
        int unsigned pick;
        int unsigned f_val;
        int unsigned f_eff;
        int unsigned w_val;
        int unsigned h_val;
        int unsigned w_eff;
        int unsigned h_eff;
        int unsigned frame_px;
        int unsigned count;
        int          pause_at;
        t_tone       tone;

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset configuration, no block completes
        send_pixel('{8'hFF, 8'h00, 8'hFF, 8'h00});
        send_pixel('{8'h00, 8'hFF, 8'h00, 8'hFF});

        // single 2x2 block, saturated then zero channels
        configure(2, 2, 2);
        repeat (4) send_pixel('1);
        repeat (4) send_pixel('0);

        // zero size and factor read as one: every pixel is its own frame
        configure(0, 0, 0);
        send_pixel('{8'h01, 8'h80, 8'h7F, 8'hFE});
        send_pixel('{8'hFE, 8'h7F, 8'h80, 8'h01});
        send_pixel('{8'hA5, 8'h5A, 8'hC3, 8'h3C});

        // factor over the limit and bigger than the image: nothing comes out
        configure(3, 3, 31);
        repeat (3) send_pixel('1);

        // write in mid frame restarts at top-left, truncating mean
        configure(2, 2, 2);
        send_pixel('{8'h10, 8'h20, 8'h30, 8'h40});
        send_pixel('{8'h50, 8'h60, 8'h70, 8'h80});
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 2);
        send_pixel('{8'hFF, 8'hFE, 8'h01, 8'h80});
        send_pixel('{8'h00, 8'hFF, 8'h02, 8'h80});
        send_pixel('{8'hFF, 8'hFE, 8'h03, 8'h80});
        send_pixel('{8'h01, 8'hFF, 8'h04, 8'h7F});

        // one row at saturated width, factor one, so the last column closes the frame
        configure(($urandom_range(0, 1) != 0) ? 1024 : $urandom_range(1025, 2047), 0, 1);
        repeat (1024) begin
            tone = t_tone'($urandom_range(0, 3));
            send_pixel('{tone_value(tone), tone_value(tone), tone_value(tone), tone_value(tone)});
        end

        // small random frames, mostly whole ones
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)      f_val = $urandom_range(1, 4);
            else if (pick < 80) f_val = $urandom_range(5, 8);
            else if (pick < 93) f_val = $urandom_range(9, 16);
            else                f_val = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(17, 31);
            f_eff = (f_val == 0) ? 1 : (f_val > 16) ? 16 : f_val;

            w_val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, f_eff)
                                                : $urandom_range(f_eff, f_eff + 10);
            pick  = $urandom_range(0, 99);
            if (pick < 4)       h_val = $urandom_range(1025, 2047);
            else if (pick < 14) h_val = $urandom_range(0, f_eff);
            else                h_val = $urandom_range(f_eff, f_eff + 10);
            w_eff    = (w_val == 0) ? 1 : w_val;
            h_eff    = (h_val == 0) ? 1 : (h_val > 1024) ? 1024 : h_val;
            frame_px = w_eff * h_eff;

            pick = $urandom_range(0, 99);
            if (h_eff > 64)
                count = $urandom_range(1, w_eff * f_eff * 2);
            else if (pick < 65)
                count = (frame_px > 300) ? frame_px : frame_px * $urandom_range(1, 2);
            else if (pick < 85)
                count = $urandom_range(1, frame_px);
            else
                count = frame_px + $urandom_range(1, frame_px);
            // keep the total near the planned number of pixels
            if (count > RANDOM_PIXELS - sent) count = RANDOM_PIXELS - sent;

            pause_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, count - 1) : -1;
            tone     = t_tone'($urandom_range(0, 3));

            configure(w_val, h_val, f_val);
            for (int unsigned n = 0; n < count; n++) begin
                // hold off until every mean so far has come out
                if (n == pause_at && pending != 0) begin
                    i_valid = 1'b0;
                    drain_results();
                end
                send_pixel('{tone_value(tone), tone_value(tone),
                             tone_value(tone), tone_value(tone)});
            end
            sent += count;
        end

        // drain, then allow a stray beat to show up
        i_valid = 1'b0;
        drain_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
